@@ rtl/rrs_pkg.sv @@
// ----------------------------------------------------------------------------
// rrs_pkg
// Types, codes and defaults shared by the round-robin scheduler modules.
// ----------------------------------------------------------------------------
package rrs_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_WIDTH_DEF    = 8;

	localparam logic [7:0]  QUANTUM_RST = 8'd10;
	localparam logic [15:0] SLICE_MAX   = 16'hFFFF;
	localparam logic [7:0]  IDLE_ID_MAX = 8'd1;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_POP    = 2'd2,
		REQ_TICK   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP,
		ST_WALK,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic clear;
		logic tick;
		logic busy;
		logic pop_ok;
	} stat_evt_t;

	typedef struct packed {
		logic       next_valid;
		logic [7:0] next_id;
		logic       add_dropped;
	} res_t;

endpackage

@@ rtl/rrs_ram.sv @@
// ----------------------------------------------------------------------------
// rrs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/rrs_stats.sv @@
// ----------------------------------------------------------------------------
// rrs_stats
// Quantum register, slice counter and the switch, idle and tick counters.
// ----------------------------------------------------------------------------
module rrs_stats import rrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  stat_evt_t   evt,
	output logic        resched,
	output logic [31:0] switch_count,
	output logic [31:0] idle_count,
	output logic [31:0] tick_count
);

	logic [7:0]  quantum_q;
	logic [15:0] slice_q;
	logic [15:0] slice_nxt;
	logic        resched_q;
	logic [31:0] switches_q;
	logic [31:0] idle_q;
	logic [31:0] ticks_q;

	assign slice_nxt = (slice_q == SLICE_MAX) ? slice_q : slice_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q  <= QUANTUM_RST;
			slice_q    <= '0;
			resched_q  <= 1'b0;
			switches_q <= '0;
			idle_q     <= '0;
			ticks_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				quantum_q <= cfg_wr_data;
			end
			if (evt.clear) begin
				resched_q <= 1'b0;
			end
			if (evt.pop_ok) begin
				switches_q <= switches_q + 32'd1;
				slice_q    <= '0;
			end
			if (evt.tick) begin
				ticks_q <= ticks_q + 32'd1;
				if (evt.busy) begin
					slice_q   <= slice_nxt;
					resched_q <= (slice_nxt >= {8'd0, quantum_q});
				end else begin
					idle_q <= idle_q + 32'd1;
				end
			end
		end
	end

	assign resched      = resched_q;
	assign switch_count = switches_q;
	assign idle_count   = idle_q;
	assign tick_count   = ticks_q;

endmodule

@@ rtl/rrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrs_ctrl
// Request sequencer: circular queue pointers over the slot RAM, pop read,
// and the remove walk that finds an ID and shifts the tail down by one.
// ----------------------------------------------------------------------------
module rrs_ctrl import rrs_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int ID_WIDTH    = ID_WIDTH_DEF,
	localparam int IDX_W = $clog2(QUEUE_DEPTH),
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          req_type,
	input  logic [7:0]          task_id,
	input  logic                running_valid,
	input  logic [7:0]          running_id,
	input  logic                out_free,
	output logic                resp_load,
	output res_t                res,
	output logic [CNT_W-1:0]    count,
	output stat_evt_t           evt,
	output logic                mem_we,
	output logic [IDX_W-1:0]    mem_waddr,
	output logic [ID_WIDTH-1:0] mem_wdata,
	output logic [IDX_W-1:0]    mem_raddr,
	input  logic [ID_WIDTH-1:0] mem_rdata
);

	localparam int SUM_W = CNT_W + 1;

	function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] base,
			input logic [CNT_W-1:0] k);
		logic [SUM_W-1:0] s;
		s = SUM_W'(base) + SUM_W'(k);
		if (s >= SUM_W'(QUEUE_DEPTH)) begin
			s = s - SUM_W'(QUEUE_DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	state_t              state_q, state_d;
	req_t                req_q;
	logic [ID_WIDTH-1:0] id_q;
	logic                run_busy_q;
	logic [IDX_W-1:0]    head_q;
	logic [IDX_W-1:0]    head_inc;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    rd_pos_q;
	logic [CNT_W-1:0]    pos_s1;
	logic                vld_s1;
	logic                found_q;
	res_t                res_q;
	logic                full;
	logic                walk_issue;
	logic                walk_done;

	assign full       = (count_q >= CNT_W'(QUEUE_DEPTH));
	assign head_inc   = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign walk_issue = (state_q == ST_WALK) && (rd_pos_q < count_q);
	assign walk_done  = (state_q == ST_WALK) && (rd_pos_q == count_q) && !vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = slot_at(head_q, count_q);
		mem_wdata = id_q;
		mem_raddr = head_q;
		evt       = '0;
		resp_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					evt.clear = 1'b1;
					state_d   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (req_q)
					REQ_ADD: begin
						mem_we  = !full;
						state_d = ST_RESP;
					end
					REQ_REMOVE: begin
						state_d = ST_WALK;
					end
					REQ_POP: begin
						state_d = (count_q != '0) ? ST_POP : ST_RESP;
					end
					REQ_TICK: begin
						evt.tick = 1'b1;
						evt.busy = run_busy_q;
						state_d  = ST_RESP;
					end
				endcase
			end
			ST_POP: begin
				evt.pop_ok = 1'b1;
				state_d    = ST_RESP;
			end
			ST_WALK: begin
				mem_raddr = slot_at(head_q, rd_pos_q);
				if (vld_s1 && found_q) begin
					mem_we    = 1'b1;
					mem_waddr = slot_at(head_q, pos_s1 - 1'b1);
					mem_wdata = mem_rdata;
				end
				if (walk_done) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					resp_load = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			rd_pos_q <= '0;
			vld_s1   <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			if (state_q == ST_EXEC) begin
				if (req_q == REQ_ADD && !full) begin
					count_q <= count_q + 1'b1;
				end
				rd_pos_q <= '0;
				vld_s1   <= 1'b0;
				found_q  <= 1'b0;
			end
			if (state_q == ST_POP) begin
				head_q  <= head_inc;
				count_q <= count_q - 1'b1;
			end
			if (state_q == ST_WALK) begin
				vld_s1 <= walk_issue;
				if (walk_issue) begin
					rd_pos_q <= rd_pos_q + 1'b1;
				end
				if (vld_s1 && !found_q && mem_rdata == id_q) begin
					found_q <= 1'b1;
				end
				if (walk_done && found_q) begin
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			req_q      <= req_t'(req_type);
			id_q       <= ID_WIDTH'(task_id);
			run_busy_q <= running_valid && (running_id > IDLE_ID_MAX);
			res_q      <= '0;
		end
		if (state_q == ST_EXEC && req_q == REQ_ADD && full) begin
			res_q.add_dropped <= 1'b1;
		end
		if (state_q == ST_POP) begin
			res_q.next_valid <= 1'b1;
			res_q.next_id    <= 8'(mem_rdata);
		end
		if (walk_issue) begin
			pos_s1 <= rd_pos_q;
		end
	end

	assign res   = res_q;
	assign count = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q < IDX_W'(QUEUE_DEPTH - 1) || head_q == IDX_W'(QUEUE_DEPTH - 1))
		else $error("head pointer out of range");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POP |=> count_q == $past(count_q) - 1'b1)
		else $error("pop did not take one entry");

endmodule

@@ rtl/round_robin_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// round_robin_scheduler_unit
// Round-robin time-slice scheduler over a circular queue of task IDs held in
// a slot RAM, with context-switch, idle and tick counters.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------------
//   in      | in_valid / in_ready    | req_type, task_id, running_valid,
//           |                        | running_id
//   out     | out_valid / out_ready  | next_valid, next_id, resched, add_dropped,
//           |                        | switch_count, idle_count, tick_count,
//           |                        | pending_count
//   cfg     | cfg_wr_en              | cfg_wr_data (quantum)
//
// One request at a time. Add and tick pass an execute step, then the response
// step loads the output register; pop adds a pop step. The next request is
// taken in the cycle after the response step. Remove walks the queue
// through the slot RAM one entry per cycle (one read port, registered read).
// The next request is taken while the previous result waits in the output
// register; a stalled output holds the sequencer in its response step.
// Reset clears queue pointers and counters; the quantum resets to 10.
// ----------------------------------------------------------------------------
module round_robin_scheduler_unit import rrs_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [7:0]  task_id,
	input  logic        running_valid,
	input  logic [7:0]  running_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        next_valid,
	output logic [7:0]  next_id,
	output logic        resched,
	output logic        add_dropped,
	output logic [31:0] switch_count,
	output logic [31:0] idle_count,
	output logic [31:0] tick_count,
	output logic [4:0]  pending_count
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic                out_valid_q;
	logic                out_free;
	logic                resp_load;
	res_t                res;
	logic [CNT_W-1:0]    count;
	stat_evt_t           evt;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	logic [ID_WIDTH-1:0] mem_wdata;
	logic [IDX_W-1:0]    mem_raddr;
	logic [ID_WIDTH-1:0] mem_rdata;
	logic                st_resched;
	logic [31:0]         st_switch;
	logic [31:0]         st_idle;
	logic [31:0]         st_tick;

	logic                next_valid_q;
	logic [7:0]          next_id_q;
	logic                resched_q;
	logic                add_dropped_q;
	logic [31:0]         switch_count_q;
	logic [31:0]         idle_count_q;
	logic [31:0]         tick_count_q;
	logic [4:0]          pending_count_q;

	assign out_free = !out_valid_q || out_ready;

	rrs_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_WIDTH    (ID_WIDTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.task_id       (task_id),
		.running_valid (running_valid),
		.running_id    (running_id),
		.out_free      (out_free),
		.resp_load     (resp_load),
		.res           (res),
		.count         (count),
		.evt           (evt),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata)
	);

	rrs_ram #(
		.WIDTH (ID_WIDTH),
		.DEPTH (QUEUE_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rrs_stats u_stats (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.evt          (evt),
		.resched      (st_resched),
		.switch_count (st_switch),
		.idle_count   (st_idle),
		.tick_count   (st_tick)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_load) begin
			next_valid_q    <= res.next_valid;
			next_id_q       <= res.next_id;
			resched_q       <= st_resched;
			add_dropped_q   <= res.add_dropped;
			switch_count_q  <= st_switch;
			idle_count_q    <= st_idle;
			tick_count_q    <= st_tick;
			pending_count_q <= 5'(count);
		end
	end

	assign out_valid     = out_valid_q;
	assign next_valid    = next_valid_q;
	assign next_id       = next_id_q;
	assign resched       = resched_q;
	assign add_dropped   = add_dropped_q;
	assign switch_count  = switch_count_q;
	assign idle_count    = idle_count_q;
	assign tick_count    = tick_count_q;
	assign pending_count = pending_count_q;

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous one in progress");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for round_robin_scheduler_unit. Directed requests cover
// empty, full and duplicate-ID queues, idle and busy ticks and several quanta.
// Random traffic then runs in phases with and without sender gaps and
// receiver stalls. An in-bench scheduler model predicts every result and a
// checker compares each output transfer.
// ----------------------------------------------------------------------------
module tb_top import rrs_pkg::*; ();

	localparam int QDEPTH      = QUEUE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 400_000;
	localparam int DRAIN_WAIT  = 32;
	localparam int PRINT_LIMIT = 40;

	typedef struct {
		req_t       req;
		logic [7:0] task_id;
		logic       running_valid;
		logic [7:0] running_id;
	} sched_req_t;

	typedef struct {
		logic        next_valid;
		logic [7:0]  next_id;
		logic        resched;
		logic        add_dropped;
		logic [31:0] switch_count;
		logic [31:0] idle_count;
		logic [31:0] tick_count;
		logic [4:0]  pending_count;
	} sched_result_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_wr_en     = 1'b0;
	logic [7:0]  cfg_wr_data   = 8'd0;
	logic        in_valid      = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type      = REQ_ADD;
	logic [7:0]  task_id       = 8'd0;
	logic        running_valid = 1'b0;
	logic [7:0]  running_id    = 8'd0;
	logic        out_valid;
	logic        out_ready     = 1'b0;
	logic        next_valid;
	logic [7:0]  next_id;
	logic        resched;
	logic        add_dropped;
	logic [31:0] switch_count;
	logic [31:0] idle_count;
	logic [31:0] tick_count;
	logic [4:0]  pending_count;

	// scheduler model state
	logic [7:0]  waiting_ids[$];
	logic [15:0] slice_used     = '0;
	logic [31:0] switch_total   = '0;
	logic [31:0] idle_total     = '0;
	logic [31:0] tick_total     = '0;
	logic [7:0]  quantum_now    = QUANTUM_RST;

	sched_result_t results_due[$];

	int error_count     = 0;
	int cycle_count     = 0;
	int sender_idle_pct = 0;
	int recv_stall_pct  = 0;
	int hold_off_cycles = 0;

	round_robin_scheduler_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.task_id      (task_id),
		.running_valid(running_valid),
		.running_id   (running_id),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.next_valid   (next_valid),
		.next_id      (next_id),
		.resched      (resched),
		.add_dropped  (add_dropped),
		.switch_count (switch_count),
		.idle_count   (idle_count),
		.tick_count   (tick_count),
		.pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			out_ready       <= 1'b0;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", field, got, want));
	endtask

	always @(posedge clk) begin : result_check
		sched_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				report_mismatch("result transfer with nothing outstanding");
			end else begin
				want = results_due.pop_front();
				check_field("next_valid",    32'(next_valid),    32'(want.next_valid));
				check_field("next_id",       32'(next_id),       32'(want.next_id));
				check_field("resched",       32'(resched),       32'(want.resched));
				check_field("add_dropped",   32'(add_dropped),   32'(want.add_dropped));
				check_field("switch_count",  switch_count,       want.switch_count);
				check_field("idle_count",    idle_count,         want.idle_count);
				check_field("tick_count",    tick_count,         want.tick_count);
				check_field("pending_count", 32'(pending_count), 32'(want.pending_count));
			end
		end
	end

	function automatic sched_result_t apply_request(input sched_req_t r);
		sched_result_t res;
		int            k;
		res = '{default: '0};
		case (r.req)
			REQ_ADD: begin
				if (waiting_ids.size() >= QDEPTH)
					res.add_dropped = 1'b1;
				else
					waiting_ids.push_back(r.task_id);
			end
			REQ_REMOVE: begin
				for (k = 0; k < waiting_ids.size(); k++) begin
					if (waiting_ids[k] == r.task_id) begin
						waiting_ids.delete(k);
						break;
					end
				end
			end
			REQ_POP: begin
				if (waiting_ids.size() > 0) begin
					res.next_valid = 1'b1;
					res.next_id    = waiting_ids.pop_front();
					switch_total++;
					slice_used = '0;
				end
			end
			default: begin
				tick_total++;
				if (r.running_valid && r.running_id > IDLE_ID_MAX) begin
					if (slice_used != SLICE_MAX)
						slice_used++;
					res.resched = (slice_used >= {8'd0, quantum_now});
				end else begin
					idle_total++;
				end
			end
		endcase
		res.switch_count  = switch_total;
		res.idle_count    = idle_total;
		res.tick_count    = tick_total;
		res.pending_count = 5'(waiting_ids.size());
		return res;
	endfunction

	task automatic send_request(input req_t req, input logic [7:0] id,
			input logic run_valid, input logic [7:0] run_id);
		sched_req_t r;
		r = '{req, id, run_valid, run_id};
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		req_type      <= req;
		task_id       <= id;
		running_valid <= run_valid;
		running_id    <= run_id;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		results_due.push_back(apply_request(r));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_quantum(input logic [7:0] q);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= q;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		quantum_now = q;
	endtask

	task automatic busy_ticks(input int n);
		repeat (n) send_request(REQ_TICK, 8'($urandom_range(255)), 1'b1,
			8'($urandom_range(2, 255)));
	endtask

	task automatic test_basic_requests();
		send_request(REQ_POP,    8'hFF, 1'b1, 8'hFF);
		send_request(REQ_TICK,   8'h00, 1'b0, 8'hFF);
		send_request(REQ_TICK,   8'h00, 1'b1, 8'h00);
		send_request(REQ_TICK,   8'hFF, 1'b1, 8'h01);
		send_request(REQ_TICK,   8'h00, 1'b1, 8'h02);
		send_request(REQ_REMOVE, 8'hAA, 1'b0, 8'h00);
		send_request(REQ_ADD,    8'h55, 1'b0, 8'h00);
		send_request(REQ_ADD,    8'hFF, 1'b1, 8'hFF);
		send_request(REQ_ADD,    8'h55, 1'b0, 8'h00);
		send_request(REQ_ADD,    8'h00, 1'b0, 8'h00);
		send_request(REQ_REMOVE, 8'h55, 1'b0, 8'h00);
		send_request(REQ_REMOVE, 8'h99, 1'b0, 8'h00);
		send_request(REQ_TICK,   8'h00, 1'b1, 8'hFF);
		send_request(REQ_POP,    8'h00, 1'b0, 8'h00);
		send_request(REQ_POP,    8'h00, 1'b0, 8'h00);
		send_request(REQ_POP,    8'h00, 1'b0, 8'h00);
		send_request(REQ_POP,    8'h00, 1'b0, 8'h00);
		wait_drained();
	endtask

	task automatic test_full_queue();
		int i;
		for (i = 0; i < QDEPTH; i++)
			send_request(REQ_ADD, 8'((i * 17) & 255), 1'b0, 8'h00);
		send_request(REQ_ADD,    8'h3C, 1'b0, 8'h00);
		send_request(REQ_REMOVE, 8'h77, 1'b0, 8'h00);
		send_request(REQ_ADD,    8'hC3, 1'b0, 8'h00);
		send_request(REQ_ADD,    8'h81, 1'b0, 8'h00);
		for (i = 0; i <= QDEPTH; i++)
			send_request(REQ_POP, 8'h00, 1'b0, 8'h00);
		wait_drained();
	endtask

	task automatic test_quantum_settings();
		logic [7:0] qs[5];
		int         i;
		qs = '{8'd1, 8'd0, 8'd255, 8'($urandom_range(2, 254)), QUANTUM_RST};
		for (i = 0; i < 5; i++) begin
			set_quantum(qs[i]);
			send_request(REQ_ADD, 8'h42, 1'b0, 8'h00);
			send_request(REQ_POP, 8'h00, 1'b0, 8'h00);
			busy_ticks(int'(qs[i]) / 2);
			send_request(REQ_TICK, 8'h00, 1'b0, 8'h80);
			busy_ticks(int'(qs[i]) - int'(qs[i]) / 2 + 2);
		end
		wait_drained();
	endtask

	task automatic test_output_backpressure();
		int i;
		set_quantum(8'd3);
		hold_off_cycles = 300;
		for (i = 0; i < 12; i++)
			send_request(req_t'(i % 4), 8'($urandom_range(2, 5)), 1'b1,
				8'($urandom_range(255)));
		wait_drained();
	endtask

	function automatic sched_req_t random_request(input bit fill_bias);
		sched_req_t r;
		int         pick;
		int         add_pct;
		int         pop_pct;
		pick    = $urandom_range(99);
		add_pct = fill_bias ? 55 : 20;
		pop_pct = fill_bias ? 10 : 35;
		r.task_id       = 8'($urandom_range(255));
		r.running_valid = 1'($urandom_range(1));
		r.running_id    = 8'($urandom_range(255));
		if (pick < add_pct) begin
			r.req = REQ_ADD;
			if ($urandom_range(1))
				r.task_id = 8'($urandom_range(2, 9));
		end else if (pick < add_pct + 20) begin
			r.req = REQ_REMOVE;
			if (waiting_ids.size() > 0 && $urandom_range(3) != 0)
				r.task_id = waiting_ids[$urandom_range(waiting_ids.size() - 1)];
			else if ($urandom_range(1))
				r.task_id = 8'($urandom_range(2, 9));
		end else if (pick < add_pct + 20 + pop_pct) begin
			r.req = REQ_POP;
		end else begin
			r.req = REQ_TICK;
			case ($urandom_range(3))
				0: r.running_valid = 1'b0;
				1: begin
					r.running_valid = 1'b1;
					r.running_id    = 8'($urandom_range(1));
				end
				default: begin
					r.running_valid = 1'b1;
					r.running_id    = 8'($urandom_range(2, 255));
				end
			endcase
		end
		return r;
	endfunction

	task automatic run_random_phase(input int items, input int idle_pct,
			input int stall_pct, input logic [7:0] q);
		sched_req_t r;
		int         i;
		set_quantum(q);
		sender_idle_pct = idle_pct;
		recv_stall_pct  = stall_pct;
		for (i = 0; i < items; i++) begin
			r = random_request((i / 40) % 2 == 0);
			send_request(r.req, r.task_id, r.running_valid, r.running_id);
		end
		wait_drained();
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
	endtask

	task automatic test_random_traffic();
		run_random_phase(330, 0,  0,  8'd4);
		run_random_phase(330, 70, 0,  8'($urandom_range(1, 12)));
		run_random_phase(330, 0,  70, 8'd255);
		run_random_phase(330, 26, 26, 8'd2);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_requests();
		test_full_queue();
		test_quantum_settings();
		test_output_backpressure();
		test_random_traffic();
		wait_drained();
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
